// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the splat paint RTL.
// Each macro expects clk_i and rst_ni to be visible in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define SAPR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SAPR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/sapr_pkg.sv
// Package for the splat alpha paint and renormalization block.
// Holds widths, the configuration register codes and the types passed between modules.
package sapr_pkg;

  localparam int unsigned CH_MAX                = 8;
  localparam int unsigned CHANNEL_COUNT_DEFAULT = 8;
  localparam int unsigned CH_IDX_W              = 3;
  localparam int unsigned ALPHA_W               = 8;
  localparam int unsigned WEIGHT_W              = 17;
  localparam int unsigned FRAC_W                = 16;
  localparam int unsigned QUO_W                 = ALPHA_W;
  localparam int unsigned PROD_W                = 2 * ALPHA_W;
  localparam int unsigned CFG_IDX_W             = 2;
  localparam int unsigned CFG_DATA_W            = 3;

  localparam logic [ALPHA_W-1:0] ALPHA_MAX = 8'd255;

  typedef logic [ALPHA_W-1:0] alpha_t;
  typedef alpha_t [CH_MAX-1:0] alpha_vec_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef prod_t [CH_MAX-1:0] prod_vec_t;
  typedef logic [QUO_W-1:0] quo_t;
  typedef quo_t [CH_MAX-1:0] quo_vec_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAINT_CHANNEL = 2'd0,
    CFG_PAINT_ACTIVE  = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic                paint_active;
    logic [CH_IDX_W-1:0] paint_channel;
  } cfg_t;

  // Per-cell side information that rides alongside the divider lanes.
  typedef struct packed {
    logic              painted;
    logic [CH_MAX-1:0] sel;
    alpha_vec_t        alpha;
  } side_t;

endpackage

// File: hw/rtl/sapr_cell_if.sv
// Input channel interface: one terrain cell per transaction.
// Depends on sapr_pkg for the field widths.
interface sapr_cell_if import sapr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                apply;
  logic [WEIGHT_W-1:0] weight;
  alpha_t              in_alpha_0;
  alpha_t              in_alpha_1;
  alpha_t              in_alpha_2;
  alpha_t              in_alpha_3;
  alpha_t              in_alpha_4;
  alpha_t              in_alpha_5;
  alpha_t              in_alpha_6;
  alpha_t              in_alpha_7;

  modport source (
    output valid, apply, weight, in_alpha_0, in_alpha_1, in_alpha_2, in_alpha_3,
           in_alpha_4, in_alpha_5, in_alpha_6, in_alpha_7,
    input  ready
  );

  modport sink (
    input  valid, apply, weight, in_alpha_0, in_alpha_1, in_alpha_2, in_alpha_3,
           in_alpha_4, in_alpha_5, in_alpha_6, in_alpha_7,
    output ready
  );
endinterface

// File: hw/rtl/sapr_res_if.sv
// Result channel interface: one painted cell per transaction.
// Depends on sapr_pkg for the field widths.
interface sapr_res_if import sapr_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   painted;
  alpha_t out_alpha_0;
  alpha_t out_alpha_1;
  alpha_t out_alpha_2;
  alpha_t out_alpha_3;
  alpha_t out_alpha_4;
  alpha_t out_alpha_5;
  alpha_t out_alpha_6;
  alpha_t out_alpha_7;

  modport source (
    output valid, painted, out_alpha_0, out_alpha_1, out_alpha_2, out_alpha_3,
           out_alpha_4, out_alpha_5, out_alpha_6, out_alpha_7,
    input  ready
  );

  modport sink (
    input  valid, painted, out_alpha_0, out_alpha_1, out_alpha_2, out_alpha_3,
           out_alpha_4, out_alpha_5, out_alpha_6, out_alpha_7,
    output ready
  );
endinterface

// File: hw/rtl/sapr_cfg_if.sv
// Configuration write channel interface: register index and write data.
// Depends on sapr_pkg for the field widths.
interface sapr_cfg_if import sapr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hw/rtl/splat_alpha_paint_renorm.sv
// Top level of the splat alpha paint and renormalization block.
// Depends on sapr_pkg, the three channel interfaces, sapr_front, sapr_lane, sapr_merge.
`include "assert_macros.svh"

// One terrain cell enters per transaction on cell_i and leaves, painted or unchanged, as
// one transaction on res_o. The block takes a new cell every clock cycle while cell_i.ready
// is high. A cell passes through eleven registers: two front stages (paint amount and raise,
// then the sum of the other channels and one product per channel), eight divider stages, and
// the output register. The first of them loads at the accepting edge; the cell then moves
// through the front, divider and output registers in turn, and res_o.valid stays high
// until the sink takes it. The eight stages are the restoring
// divider in every lane, one quotient bit each, which produce
// floor(alpha * (255 - amount) / sum_of_others) exactly.
// Each pipeline stage holds its cell until the next one can take it, so bubbles close up
// and up to eleven cells can be in flight while the sink stalls; cell_i.ready falls only
// when every stage and the output register are full. Configuration (paint_channel at
// index 0, paint_active at index 1) is written through cfg_i, which is always ready;
// writes to other indexes are dropped. Write it only while no cell is in flight.
module splat_alpha_paint_renorm import sapr_pkg::*; #(
  parameter int unsigned ChannelCount = CHANNEL_COUNT_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sapr_cfg_if.sink    cfg_i,
  sapr_cell_if.sink   cell_i,
  sapr_res_if.source  res_o
);

  localparam int unsigned SumW  = ALPHA_W + $clog2(ChannelCount);
  localparam int unsigned NPipe = 2 + QUO_W;

  // Configuration registers.
  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_PAINT_CHANNEL: cfg_d.paint_channel = cfg_i.data[CH_IDX_W-1:0];
        CFG_PAINT_ACTIVE:  cfg_d.paint_active  = cfg_i.data[0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_i.ready = 1'b1;

  // Pipeline occupancy. A stage loads when it is empty or when the stage after it loads.
  logic [NPipe-1:0] v_q;
  logic [NPipe-1:0] v_d;
  logic [NPipe-1:0] en;
  logic             en_out;
  logic             out_v_q;
  logic             out_v_d;

  always_comb begin
    en_out          = !out_v_q || res_o.ready;
    en[NPipe-1]     = !v_q[NPipe-1] || en_out;
    for (int k = NPipe - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d[0] = en[0] ? cell_i.valid : v_q[0];
    for (int k = 1; k < NPipe; k++) begin
      v_d[k] = en[k] ? v_q[k-1] : v_q[k];
    end
    out_v_d = en_out ? v_q[NPipe-1] : out_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '0;
      out_v_q <= 1'b0;
    end else begin
      v_q     <= v_d;
      out_v_q <= out_v_d;
    end
  end

  assign cell_i.ready = en[0];

  // Input fields gathered into a vector.
  alpha_vec_t in_alpha;

  assign in_alpha[0] = cell_i.in_alpha_0;
  assign in_alpha[1] = cell_i.in_alpha_1;
  assign in_alpha[2] = cell_i.in_alpha_2;
  assign in_alpha[3] = cell_i.in_alpha_3;
  assign in_alpha[4] = cell_i.in_alpha_4;
  assign in_alpha[5] = cell_i.in_alpha_5;
  assign in_alpha[6] = cell_i.in_alpha_6;
  assign in_alpha[7] = cell_i.in_alpha_7;

  side_t           front_side;
  logic [SumW-1:0] front_total;
  prod_vec_t       front_prod;

  sapr_front #(
    .ChannelCount (ChannelCount),
    .SumW         (SumW)
  ) u_front (
    .clk_i    (clk_i),
    .en_i     (en[1:0]),
    .cfg_i    (cfg_q),
    .apply_i  (cell_i.apply),
    .weight_i (cell_i.weight),
    .alpha_i  (in_alpha),
    .side_o   (front_side),
    .total_o  (front_total),
    .prod_o   (front_prod)
  );

  // One divider lane per channel in use; the others never select a quotient.
  quo_vec_t lane_quo;

  for (genvar i = 0; i < CH_MAX; i++) begin : g_lane
    if (i < ChannelCount) begin : g_used
      sapr_lane #(
        .SumW (SumW)
      ) u_lane (
        .clk_i  (clk_i),
        .en_i   (en[NPipe-1:2]),
        .prod_i (front_prod[i]),
        .div_i  (front_total),
        .quo_o  (lane_quo[i])
      );
    end else begin : g_unused
      assign lane_quo[i] = '0;
    end
  end

  // Side information travels in step with the divider stages.
  side_t side_q [QUO_W];

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < QUO_W; s++) begin
      if (en[2+s]) begin
        side_q[s] <= (s == 0) ? front_side : side_q[(s == 0) ? 0 : s - 1];
      end
    end
  end

  logic       out_painted;
  alpha_vec_t out_alpha;

  sapr_merge #(
    .ChannelCount (ChannelCount)
  ) u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en_out),
    .valid_i   (out_v_q),
    .side_i    (side_q[QUO_W-1]),
    .quo_i     (lane_quo),
    .painted_o (out_painted),
    .alpha_o   (out_alpha)
  );

  assign res_o.valid       = out_v_q;
  assign res_o.painted     = out_painted;
  assign res_o.out_alpha_0 = out_alpha[0];
  assign res_o.out_alpha_1 = out_alpha[1];
  assign res_o.out_alpha_2 = out_alpha[2];
  assign res_o.out_alpha_3 = out_alpha[3];
  assign res_o.out_alpha_4 = out_alpha[4];
  assign res_o.out_alpha_5 = out_alpha[5];
  assign res_o.out_alpha_6 = out_alpha[6];
  assign res_o.out_alpha_7 = out_alpha[7];

  // Back pressure can only start at a stalled result.
  `SAPR_ASSERT_IMP(stall_from_output_a, !cell_i.ready, res_o.valid && !res_o.ready, "bad stall")

  // A finished cell moves into an empty output register on the next edge.
  `SAPR_ASSERT_NXT(drain_to_output_a, v_q[NPipe-1] && !out_v_q, out_v_q, "output not loaded")

endmodule

// File: hw/rtl/sapr_front.sv
// Front end: paint amount, channel raise, sum of the other channels and lane products.
// Two register stages; depends on sapr_pkg.
module sapr_front import sapr_pkg::*; #(
  parameter int unsigned ChannelCount = CHANNEL_COUNT_DEFAULT,
  parameter int unsigned SumW         = ALPHA_W + $clog2(ChannelCount)
) (
  input  logic                clk_i,
  input  logic [1:0]          en_i,
  input  cfg_t                cfg_i,
  input  logic                apply_i,
  input  logic [WEIGHT_W-1:0] weight_i,
  input  alpha_vec_t          alpha_i,
  output side_t               side_o,
  output logic [SumW-1:0]     total_o,
  output prod_vec_t           prod_o
);

  localparam int unsigned ScaledW = WEIGHT_W + ALPHA_W;
  localparam int unsigned AmtW    = ScaledW - FRAC_W;

  logic [ScaledW-1:0]  scaled;
  logic [AmtW-1:0]     amt_raw;
  alpha_t              amount;
  logic                ch_ok;
  logic                hit;
  alpha_vec_t          alpha1_d;
  alpha_t              room1_d;

  logic                painted1_q;
  logic [CH_IDX_W-1:0] ch1_q;
  alpha_t              room1_q;
  alpha_vec_t          alpha1_q;

  logic [SumW-1:0]     total_d;
  side_t               side_d;
  prod_vec_t           prod_d;

  side_t               side_q;
  logic [SumW-1:0]     total_q;
  prod_vec_t           prod_q;

  // Stage one: weight * 255 as a shift and subtract, then the raise decision.
  always_comb begin
    scaled  = {weight_i, {ALPHA_W{1'b0}}} - ScaledW'(weight_i);
    amt_raw = scaled[ScaledW-1:FRAC_W];
    amount  = (amt_raw > AmtW'(ALPHA_MAX)) ? ALPHA_MAX : amt_raw[ALPHA_W-1:0];
    ch_ok   = {1'b0, cfg_i.paint_channel} < (CH_IDX_W + 1)'(ChannelCount);
    hit     = cfg_i.paint_active && apply_i && ch_ok &&
              (alpha_i[cfg_i.paint_channel] < amount);
    room1_d = ALPHA_MAX - amount;
    alpha1_d = alpha_i;
    if (hit) begin
      alpha1_d[cfg_i.paint_channel] = amount;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      painted1_q <= hit;
      ch1_q      <= cfg_i.paint_channel;
      room1_q    <= room1_d;
      alpha1_q   <= alpha1_d;
    end
  end

  // Stage two: sum of the other channels in use and one product per lane.
  always_comb begin
    total_d = '0;
    prod_d  = '0;
    for (int i = 0; i < CH_MAX; i++) begin
      if ((i < ChannelCount) && (CH_IDX_W'(i) != ch1_q)) begin
        total_d = total_d + SumW'(alpha1_q[i]);
      end
    end
    side_d.painted = painted1_q;
    side_d.alpha   = alpha1_q;
    for (int i = 0; i < CH_MAX; i++) begin
      side_d.sel[i] = painted1_q && (total_d != '0) && (i < ChannelCount) &&
                      (CH_IDX_W'(i) != ch1_q);
      if (i < ChannelCount) begin
        prod_d[i] = PROD_W'(alpha1_q[i]) * PROD_W'(room1_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      side_q  <= side_d;
      total_q <= total_d;
      prod_q  <= prod_d;
    end
  end

  assign side_o  = side_q;
  assign total_o = total_q;
  assign prod_o  = prod_q;

endmodule

// File: hw/rtl/sapr_lane.sv
// One divider lane: pipelined restoring division, one quotient bit per stage.
// Depends on sapr_pkg; where a quotient is used, dividend < 256 * divisor.
module sapr_lane import sapr_pkg::*; #(
  parameter int unsigned SumW = ALPHA_W + $clog2(CHANNEL_COUNT_DEFAULT)
) (
  input  logic             clk_i,
  input  logic [QUO_W-1:0] en_i,
  input  prod_t            prod_i,
  input  logic [SumW-1:0]  div_i,
  output quo_t             quo_o
);

  localparam int unsigned RemW = SumW + QUO_W;

  logic [RemW-1:0] rem_q [QUO_W-1];
  logic [SumW-1:0] div_q [QUO_W-1];
  quo_t            quo_q [QUO_W];

  logic [RemW-1:0] rem_src [QUO_W];
  logic [SumW-1:0] div_src [QUO_W];
  quo_t            quo_src [QUO_W];
  logic [RemW-1:0] dsh     [QUO_W];
  logic [RemW-1:0] rem_d   [QUO_W];
  quo_t            quo_d   [QUO_W];

  always_comb begin
    rem_src[0] = RemW'(prod_i);
    div_src[0] = div_i;
    quo_src[0] = '0;
    for (int s = 1; s < QUO_W; s++) begin
      rem_src[s] = rem_q[s-1];
      div_src[s] = div_q[s-1];
      quo_src[s] = quo_q[s-1];
    end
    for (int s = 0; s < QUO_W; s++) begin
      dsh[s]   = RemW'(div_src[s]) << (QUO_W - 1 - s);
      quo_d[s] = quo_src[s];
      if (rem_src[s] >= dsh[s]) begin
        rem_d[s] = rem_src[s] - dsh[s];
        quo_d[s][QUO_W-1-s] = 1'b1;
      end else begin
        rem_d[s] = rem_src[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int s = 0; s < QUO_W; s++) begin
      if (en_i[s]) begin
        quo_q[s] <= quo_d[s];
        if (s < QUO_W - 1) begin
          rem_q[s] <= rem_d[s];
          div_q[s] <= div_src[s];
        end
      end
    end
  end

  assign quo_o = quo_q[QUO_W-1];

endmodule

// File: hw/rtl/sapr_merge.sv
// Merging stage: picks each lane's quotient or its unchanged alpha into the output register.
// Depends on sapr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sapr_merge import sapr_pkg::*; #(
  parameter int unsigned ChannelCount = CHANNEL_COUNT_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       valid_i,
  input  side_t      side_i,
  input  quo_vec_t   quo_i,
  output logic       painted_o,
  output alpha_vec_t alpha_o
);

  localparam int unsigned OutSumW = ALPHA_W + $clog2(CH_MAX) + 1;

  alpha_vec_t         alpha_d;
  alpha_vec_t         alpha_q;
  logic               painted_q;
  logic [OutSumW-1:0] out_sum;

  always_comb begin
    for (int i = 0; i < CH_MAX; i++) begin
      alpha_d[i] = side_i.sel[i] ? quo_i[i] : side_i.alpha[i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      painted_q <= side_i.painted;
      alpha_q   <= alpha_d;
    end
  end

  assign painted_o = painted_q;
  assign alpha_o   = alpha_q;

  always_comb begin
    out_sum = '0;
    for (int i = 0; i < CH_MAX; i++) begin
      if (i < ChannelCount) begin
        out_sum = out_sum + OutSumW'(alpha_q[i]);
      end
    end
  end

  // After a paint the channels in use never add up to more than full coverage.
  `SAPR_ASSERT_IMP(painted_sum_bound_a, valid_i && painted_q, out_sum <= OutSumW'(ALPHA_MAX), "painted cell alphas exceed full coverage")

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for splat_alpha_paint_renorm: paints terrain cells and checks
// each result against a cycle-free predictor. Depends on sapr_pkg and the three channel
// interfaces (sapr_cfg_if, sapr_cell_if, sapr_res_if).
module tb_top;
  import sapr_pkg::*;

  // The block is built with all eight channels in use.
  localparam int unsigned CHAN_COUNT = CHANNEL_COUNT_DEFAULT;

  // Extra wait after the last result before the registers are touched again.
  localparam int unsigned DRAIN_CYCLES   = 16;
  // Long receiver hold-off used to fill the pipeline and back up the input.
  localparam int unsigned HOLD_CYCLES    = 300;
  // Cycles without any transaction on any channel before the run is declared hung.
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  // Indexes outside the register list; writes to them must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  // One terrain cell as offered on the input channel.
  typedef struct packed {
    logic                apply;
    logic [WEIGHT_W-1:0] weight;
    alpha_vec_t          alpha;
  } cell_t;

  // One painted cell as returned on the result channel.
  typedef struct packed {
    logic       painted;
    alpha_vec_t alpha;
  } painted_cell_t;

  logic clk;
  logic rst_n;

  sapr_cfg_if  cfg_if ();
  sapr_cell_if cell_if ();
  sapr_res_if  res_if ();

  splat_alpha_paint_renorm #(
    .ChannelCount(CHAN_COUNT)
  ) uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_if),
    .cell_i(cell_if),
    .res_o (res_if)
  );

  // Local copy of the two configuration registers, updated on each accepted write.
  logic [CH_IDX_W-1:0] chan_model;
  logic                active_model;

  cell_t         cell_queue[$];   // cells waiting to be offered
  painted_cell_t cells_due[$];    // predicted results, oldest first
  cell_t         cell_drv;        // cell currently on the input channel
  painted_cell_t res_seen;

  logic cell_taken;
  int   error_count;
  int   quiet_cycles;
  int   hold_count;

  // Phase knobs: percentage of idle cycles on each side and the long hold-off request.
  int   src_idle_pct;
  int   sink_stall_pct;
  logic long_hold;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Paint prediction for one cell. The amount is floor(weight * 255 / 65536), clipped to
  // 255. When painting is on, the cell asks for it and the selected channel sits below the
  // amount, that channel is raised and every other channel in use is rescaled so that the
  // others share what is left of 255. With no weight in the others they stay at zero.
  function automatic painted_cell_t paint_cell(cell_t c, logic [CH_IDX_W-1:0] chan,
                                               logic active);
    painted_cell_t r;
    int unsigned   amount;
    int unsigned   room;
    int unsigned   total;
    r.painted = 1'b0;
    r.alpha   = c.alpha;
    amount    = (32'(c.weight) * 32'd255) >> FRAC_W;
    if (amount > 32'd255) begin
      amount = 32'd255;
    end
    if (active && c.apply && 32'(chan) < CHAN_COUNT && 32'(c.alpha[chan]) < amount) begin
      r.painted     = 1'b1;
      r.alpha[chan] = alpha_t'(amount);
      room          = 32'd255 - amount;
      total         = 0;
      for (int i = 0; i < CHAN_COUNT; i++) begin
        if (i != chan) begin
          total += 32'(c.alpha[i]);
        end
      end
      if (total != 0) begin
        for (int i = 0; i < CHAN_COUNT; i++) begin
          if (i != chan) begin
            r.alpha[i] = alpha_t'((32'(c.alpha[i]) * room) / total);
          end
        end
      end
    end
    return r;
  endfunction

  function automatic cell_t cell_of(logic ap, logic [WEIGHT_W-1:0] w, alpha_vec_t a);
    cell_t c;
    c.apply  = ap;
    c.weight = w;
    c.alpha  = a;
    return c;
  endfunction

  // Random cell biased toward cells that really get painted: apply mostly set, the
  // selected channel often low, and a mix of empty, full, sparse and dense alpha sets.
  function automatic cell_t random_cell(logic [CH_IDX_W-1:0] chan);
    cell_t c;
    int    pick;
    c.apply = ($urandom_range(99) < 85);
    pick    = $urandom_range(99);
    if (pick < 8) begin
      c.weight = '0;
    end else if (pick < 16) begin
      c.weight = 17'd65536;
    end else if (pick < 20) begin
      c.weight = WEIGHT_W'($urandom_range(131071, 65537));
    end else if (pick < 30) begin
      c.weight = WEIGHT_W'($urandom_range(1023));
    end else begin
      c.weight = WEIGHT_W'($urandom_range(65536));
    end
    pick = $urandom_range(9);
    for (int i = 0; i < CH_MAX; i++) begin
      case (pick)
        0:       c.alpha[i] = '0;
        1:       c.alpha[i] = ALPHA_MAX;
        2:       c.alpha[i] = '0;
        3:       c.alpha[i] = (i == ((chan + 1) % CH_MAX)) ? alpha_t'($urandom_range(255)) : '0;
        4, 5:    c.alpha[i] = alpha_t'($urandom_range(15));
        default: c.alpha[i] = alpha_t'($urandom_range(255));
      endcase
    end
    if (pick == 2 || $urandom_range(1) == 0) begin
      c.alpha[chan] = alpha_t'($urandom_range(63));
    end
    return c;
  endfunction

  // Input driver: a new cell goes out at the falling edge once the previous one was taken.
  always @(negedge clk) begin
    if (!cell_if.valid || cell_taken) begin
      if (cell_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
        cell_drv           = cell_queue.pop_front();
        cell_if.apply      <= cell_drv.apply;
        cell_if.weight     <= cell_drv.weight;
        cell_if.in_alpha_0 <= cell_drv.alpha[0];
        cell_if.in_alpha_1 <= cell_drv.alpha[1];
        cell_if.in_alpha_2 <= cell_drv.alpha[2];
        cell_if.in_alpha_3 <= cell_drv.alpha[3];
        cell_if.in_alpha_4 <= cell_drv.alpha[4];
        cell_if.in_alpha_5 <= cell_drv.alpha[5];
        cell_if.in_alpha_6 <= cell_drv.alpha[6];
        cell_if.in_alpha_7 <= cell_drv.alpha[7];
        cell_if.valid      <= 1'b1;
      end else begin
        cell_if.valid <= 1'b0;
      end
    end
  end

  // Result-side ready. When a long hold-off is requested, this process counts the stalled
  // cycles itself and then falls back to the random stall rate of the phase.
  always @(negedge clk) begin
    if (long_hold && hold_count < HOLD_CYCLES) begin
      res_if.ready <= 1'b0;
      hold_count++;
    end else begin
      if (!long_hold) begin
        hold_count = 0;
      end
      res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Monitor: predicts on each accepted cell and checks each accepted result in order.
  always @(posedge clk) begin
    cell_taken = rst_n && cell_if.valid && cell_if.ready;
    if (cell_taken) begin
      cells_due.push_back(paint_cell(cell_drv, chan_model, active_model));
    end
    if (rst_n && res_if.valid && res_if.ready) begin
      res_seen.painted  = res_if.painted;
      res_seen.alpha[0] = res_if.out_alpha_0;
      res_seen.alpha[1] = res_if.out_alpha_1;
      res_seen.alpha[2] = res_if.out_alpha_2;
      res_seen.alpha[3] = res_if.out_alpha_3;
      res_seen.alpha[4] = res_if.out_alpha_4;
      res_seen.alpha[5] = res_if.out_alpha_5;
      res_seen.alpha[6] = res_if.out_alpha_6;
      res_seen.alpha[7] = res_if.out_alpha_7;
      if (cells_due.size() == 0) begin
        $error("result transaction with no cell outstanding");
        error_count++;
      end else begin
        if (cells_due[0].painted !== res_seen.painted) begin
          $error("painted mismatch: expected %0d, got %0d",
                 cells_due[0].painted, res_seen.painted);
          error_count++;
        end
        for (int i = 0; i < CH_MAX; i++) begin
          if (cells_due[0].alpha[i] !== res_seen.alpha[i]) begin
            $error("out_alpha_%0d mismatch: expected %0d, got %0d",
                   i, cells_due[0].alpha[i], res_seen.alpha[i]);
            error_count++;
          end
        end
        void'(cells_due.pop_front());
      end
    end
  end

  // Watchdog: any transaction on any channel counts as progress.
  always @(posedge clk) begin
    if ((cell_if.valid && cell_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // One register write. The valid is left high on return so that back-to-back writes
  // never lower and raise it in the same time step; cfg_release drops it afterwards.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) begin
      @(posedge clk);
    end
    if (idx == CFG_PAINT_CHANNEL) begin
      chan_model = value;
    end else if (idx == CFG_PAINT_ACTIVE) begin
      active_model = value[0];
    end
  endtask

  task automatic cfg_release();
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Waits until every cell has been offered, accepted and answered, then lets the
  // pipeline settle before anything touches the registers again.
  task automatic wait_drained();
    while (cell_queue.size() != 0 || cell_if.valid || cells_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Knobs change at the rising edge, away from the falling-edge drivers that read them.
  task automatic run_random(int count, int src_idle, int sink_stall);
    @(posedge clk);
    src_idle_pct   = src_idle;
    sink_stall_pct = sink_stall;
    for (int i = 0; i < count; i++) begin
      cell_queue.push_back(random_cell(chan_model));
    end
    wait_drained();
  endtask

  task automatic queue_cell(cell_t c);
    @(posedge clk);
    cell_queue.push_back(c);
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = CFG_PAINT_CHANNEL;
    cfg_if.data        = '0;
    cell_if.valid      = 1'b0;
    cell_if.apply      = 1'b0;
    cell_if.weight     = '0;
    cell_if.in_alpha_0 = '0;
    cell_if.in_alpha_1 = '0;
    cell_if.in_alpha_2 = '0;
    cell_if.in_alpha_3 = '0;
    cell_if.in_alpha_4 = '0;
    cell_if.in_alpha_5 = '0;
    cell_if.in_alpha_6 = '0;
    cell_if.in_alpha_7 = '0;
    res_if.ready       = 1'b0;
    cell_drv           = '0;
    cell_taken         = 1'b0;
    chan_model         = '0;
    active_model       = 1'b0;
    error_count        = 0;
    quiet_cycles       = 0;
    hold_count         = 0;
    src_idle_pct       = 0;
    sink_stall_pct     = 0;
    long_hold          = 1'b0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Out of reset painting is off, so even a full-weight cell must pass untouched.
    queue_cell(cell_of(1'b1, 17'd65536, '0));
    queue_cell(cell_of(1'b1, 17'd65536, {8'd9, 8'd8, 8'd7, 8'd6, 8'd5, 8'd4, 8'd3, 8'd0}));
    wait_drained();

    write_reg(CFG_PAINT_CHANNEL, 3'd2);
    write_reg(CFG_PAINT_ACTIVE, 3'd1);
    cfg_release();

    // Directed cells, selected channel 2; alpha sets are listed from channel 7 down.
    queue_cell(cell_of(1'b1, 17'd0, '0));                         // zero weight
    queue_cell(cell_of(1'b1, 17'd65536, '0));                     // all-zero others
    queue_cell(cell_of(1'b1, 17'd131071,                          // weight clips at 255
                       {8'd10, 8'd20, 8'd30, 8'd40, 8'd50, 8'd60, 8'd70, 8'd80}));
    queue_cell(cell_of(1'b1, 17'h15555, {8{8'h55}}));             // above 1.0 as well
    queue_cell(cell_of(1'b1, 17'd65535, {8{8'd255}}));            // selected not below
    queue_cell(cell_of(1'b1, 17'd258, '0));                       // smallest nonzero amount
    queue_cell(cell_of(1'b1, 17'd257, '0));                       // just under one step
    queue_cell(cell_of(1'b1, 17'd32768,                           // selected equals amount
                       {8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd127, 8'd7, 8'd8}));
    queue_cell(cell_of(1'b1, 17'd32768,                           // selected above amount
                       {8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd128, 8'd7, 8'd8}));
    queue_cell(cell_of(1'b0, 17'd65536,                           // apply clear
                       {8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd0, 8'd7, 8'd8}));
    queue_cell(cell_of(1'b1, 17'd65536,                           // no room left for others
                       {8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255}));
    queue_cell(cell_of(1'b1, 17'd40000,                           // single other channel
                       {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd200}));
    queue_cell(cell_of(1'b1, 17'h0AAAA, {8{8'hAA}}));
    queue_cell(cell_of(1'b1, 17'd1,
                       {8'd255, 8'd0, 8'd128, 8'd1, 8'd254, 8'd0, 8'd64, 8'd32}));
    queue_cell(cell_of(1'b1, 17'd50000,
                       {8'd255, 8'd1, 8'd255, 8'd1, 8'd255, 8'd3, 8'd255, 8'd1}));
    queue_cell(cell_of(1'b1, 17'd65536,
                       {8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd254, 8'd1, 8'd1}));
    wait_drained();

    // Lowest channel, no idling on either side.
    write_reg(CFG_PAINT_CHANNEL, 3'd0);
    cfg_release();
    run_random(400, 0, 0);

    // Highest channel, sender mostly idle.
    write_reg(CFG_PAINT_CHANNEL, 3'd7);
    cfg_release();
    run_random(400, 75, 0);

    // Painting switched off with spare data bits set, plus writes to unused indexes.
    write_reg(CFG_PAINT_ACTIVE, 3'b110);
    write_reg(CFG_SPARE_2, 3'd7);
    write_reg(CFG_SPARE_3, 3'd5);
    write_reg(CFG_PAINT_CHANNEL, 3'd5);
    cfg_release();
    run_random(150, 0, 75);

    write_reg(CFG_PAINT_ACTIVE, 3'b111);
    write_reg(CFG_PAINT_CHANNEL, CH_IDX_W'($urandom_range(7)));
    cfg_release();
    run_random(500, 0, 75);

    write_reg(CFG_PAINT_CHANNEL, CH_IDX_W'($urandom_range(7)));
    cfg_release();
    run_random(400, 36, 36);

    // The receiver holds off for a long stretch while cells keep coming, so the pipeline
    // fills and the input stalls; afterwards it drains at full rate.
    write_reg(CFG_PAINT_CHANNEL, 3'd3);
    cfg_release();
    @(posedge clk);
    long_hold = 1'b1;
    run_random(200, 0, 0);
    @(posedge clk);
    long_hold = 1'b0;

    wait_drained();
    if (cells_due.size() != 0) begin
      $error("%0d predicted results never arrived", cells_due.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
